@@ src/mrbp_pkg.sv @@
// Shared types, codes and constants of the rectangle allocator.
`default_nettype none
package mrbp_pkg;

    localparam int CW = 13;

    typedef logic [CW-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t w;
        coord_t h;
    } rect_t;

    localparam coord_t COORD_MAX = 13'd4096;
    localparam coord_t BIN_RESET = 13'd2000;

    localparam logic CFG_BIN_WIDTH  = 1'b0;
    localparam logic CFG_BIN_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_PLACED   = 2'd0,
        STATUS_NOFIT    = 2'd1,
        STATUS_OVERFLOW = 2'd2,
        STATUS_CLEARED  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CLEAR,
        ST_SCAN,
        ST_KEEP,
        ST_CUT_FETCH,
        ST_CUT_LATCH,
        ST_CUT_PIECE,
        ST_PRUNE_OUTER,
        ST_PRUNE_LATCH,
        ST_PRUNE_INNER,
        ST_PRUNE_CHECK,
        ST_COMMIT,
        ST_RESULT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RESTART,
        OP_CLEAR,
        OP_SCAN,
        OP_KEEP_INIT,
        OP_KEEP,
        OP_CUT_FETCH,
        OP_CUT_LATCH,
        OP_CUT_PIECE,
        OP_PRUNE_INIT,
        OP_PRUNE_OUTER,
        OP_PRUNE_LATCH,
        OP_PRUNE_INNER,
        OP_COMMIT
    } op_t;

    typedef struct packed {
        op_t     op;
        logic    set_result;
        status_t result;
        logic    emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_place;
        logic free_done;
        logic found;
        logic cut_end;
        logic piece_last;
        logic outer_end;
        logic i_alive;
        logic inner_end;
        logic overflow;
        logic scr_done;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

@@ src/maxrects_bin_packer_core.sv @@
// A clear passes the dispatch, clear and result states. A placement scans the F free
// rectangles and, if one fits, keeps or splits them into N scratch entries (N <= 4F),
// prunes them pairwise via the single scratch read port and commits them unless they overflow.
// One word is worked on at a time; the next is accepted once the result is registered.
// Reset is synchronous: the free list is empty and both bin sizes return to 2000.
`default_nettype none
module maxrects_bin_packer_core #(
    parameter int MAX_FREE_RECTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // cmd, req_width, req_height
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata   // status, pos_x, pos_y, free_count
);

    mrbp_pkg::ctrl_cmd_t  cmd;
    mrbp_pkg::dp_status_t sts;
    mrbp_pkg::status_t    out_status;
    mrbp_pkg::coord_t     out_pos_x, out_pos_y;
    logic [6:0]           out_free_count;

    assign cfg_ready = 1'b1;

    mrbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrbp_datapath #(
        .MAX_FREE_RECTS (MAX_FREE_RECTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_cmd         (s_tdata[0]),
        .in_req_width   (s_tdata[13:1]),
        .in_req_height  (s_tdata[26:14]),
        .cmd            (cmd),
        .sts            (sts),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_status     (out_status),
        .out_pos_x      (out_pos_x),
        .out_pos_y      (out_pos_y),
        .out_free_count (out_free_count)
    );

    assign m_tdata = {5'd0, out_free_count, out_pos_y, out_pos_x, out_status};

endmodule
`default_nettype wire

@@ src/mrbp_ctrl.sv @@
// Sequencing state machine of the rectangle allocator.
`default_nettype none
module mrbp_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire mrbp_pkg::dp_status_t sts,
    output mrbp_pkg::ctrl_cmd_t     cmd
);

    mrbp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrbp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd.op         = mrbp_pkg::OP_NONE;
        cmd.set_result = 1'b0;
        cmd.result     = mrbp_pkg::STATUS_PLACED;
        cmd.emit       = 1'b0;
        unique case (state_reg)
            mrbp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = mrbp_pkg::OP_LOAD;
                    state_next = mrbp_pkg::ST_DISPATCH;
                end
            end
            mrbp_pkg::ST_DISPATCH: begin
                cmd.op     = mrbp_pkg::OP_RESTART;
                state_next = sts.is_place ? mrbp_pkg::ST_SCAN : mrbp_pkg::ST_CLEAR;
            end
            mrbp_pkg::ST_CLEAR: begin
                cmd.op         = mrbp_pkg::OP_CLEAR;
                cmd.set_result = 1'b1;
                cmd.result     = mrbp_pkg::STATUS_CLEARED;
                state_next     = mrbp_pkg::ST_RESULT;
            end
            mrbp_pkg::ST_SCAN: begin
                cmd.op = mrbp_pkg::OP_SCAN;
                if (sts.free_done) begin
                    if (sts.found) begin
                        cmd.op     = mrbp_pkg::OP_KEEP_INIT;
                        state_next = mrbp_pkg::ST_KEEP;
                    end else begin
                        cmd.set_result = 1'b1;
                        cmd.result     = mrbp_pkg::STATUS_NOFIT;
                        state_next     = mrbp_pkg::ST_RESULT;
                    end
                end
            end
            mrbp_pkg::ST_KEEP: begin
                cmd.op = mrbp_pkg::OP_KEEP;
                if (sts.free_done) begin
                    cmd.op     = mrbp_pkg::OP_RESTART;
                    state_next = mrbp_pkg::ST_CUT_FETCH;
                end
            end
            mrbp_pkg::ST_CUT_FETCH: begin
                cmd.op = mrbp_pkg::OP_CUT_FETCH;
                if (sts.cut_end) begin
                    cmd.op     = mrbp_pkg::OP_PRUNE_INIT;
                    state_next = mrbp_pkg::ST_PRUNE_OUTER;
                end else begin
                    state_next = mrbp_pkg::ST_CUT_LATCH;
                end
            end
            mrbp_pkg::ST_CUT_LATCH: begin
                cmd.op     = mrbp_pkg::OP_CUT_LATCH;
                state_next = mrbp_pkg::ST_CUT_PIECE;
            end
            mrbp_pkg::ST_CUT_PIECE: begin
                cmd.op = mrbp_pkg::OP_CUT_PIECE;
                if (sts.piece_last) begin
                    state_next = mrbp_pkg::ST_CUT_FETCH;
                end
            end
            mrbp_pkg::ST_PRUNE_OUTER: begin
                cmd.op = mrbp_pkg::OP_PRUNE_OUTER;
                if (sts.outer_end) begin
                    state_next = mrbp_pkg::ST_PRUNE_CHECK;
                end else if (sts.i_alive) begin
                    state_next = mrbp_pkg::ST_PRUNE_LATCH;
                end
            end
            mrbp_pkg::ST_PRUNE_LATCH: begin
                cmd.op     = mrbp_pkg::OP_PRUNE_LATCH;
                state_next = mrbp_pkg::ST_PRUNE_INNER;
            end
            mrbp_pkg::ST_PRUNE_INNER: begin
                cmd.op = mrbp_pkg::OP_PRUNE_INNER;
                if (sts.inner_end) begin
                    state_next = mrbp_pkg::ST_PRUNE_OUTER;
                end
            end
            mrbp_pkg::ST_PRUNE_CHECK: begin
                if (sts.overflow) begin
                    cmd.set_result = 1'b1;
                    cmd.result     = mrbp_pkg::STATUS_OVERFLOW;
                    state_next     = mrbp_pkg::ST_RESULT;
                end else begin
                    cmd.op     = mrbp_pkg::OP_RESTART;
                    state_next = mrbp_pkg::ST_COMMIT;
                end
            end
            mrbp_pkg::ST_COMMIT: begin
                cmd.op = mrbp_pkg::OP_COMMIT;
                if (sts.scr_done) begin
                    cmd.set_result = 1'b1;
                    cmd.result     = mrbp_pkg::STATUS_PLACED;
                    state_next     = mrbp_pkg::ST_RESULT;
                end
            end
            mrbp_pkg::ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = mrbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mrbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ src/mrbp_datapath.sv @@
// Free list, scratch list, fit search, splitting, pruning and result register.
`default_nettype none
module mrbp_datapath #(
    parameter int MAX_FREE_RECTS = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_index,
    input  wire mrbp_pkg::coord_t      cfg_data,
    input  wire logic                  in_cmd,
    input  wire mrbp_pkg::coord_t      in_req_width,
    input  wire mrbp_pkg::coord_t      in_req_height,
    input  wire mrbp_pkg::ctrl_cmd_t   cmd,
    output mrbp_pkg::dp_status_t       sts,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output mrbp_pkg::status_t          out_status,
    output mrbp_pkg::coord_t           out_pos_x,
    output mrbp_pkg::coord_t           out_pos_y,
    output logic [6:0]                 out_free_count
);

    localparam int S    = 4 * MAX_FREE_RECTS;
    localparam int FI   = $clog2(MAX_FREE_RECTS);
    localparam int CNTW = $clog2(MAX_FREE_RECTS + 1);
    localparam int SI   = $clog2(S);
    localparam int SCW  = $clog2(S + 1);
    localparam int EW   = mrbp_pkg::CW + 1;
    localparam int AW   = 2 * mrbp_pkg::CW;

    function automatic logic fn_inside(mrbp_pkg::rect_t a, mrbp_pkg::rect_t b);
        logic [EW-1:0] ax_end, ay_end, bx_end, by_end;
        ax_end = {1'b0, a.x} + {1'b0, a.w};
        ay_end = {1'b0, a.y} + {1'b0, a.h};
        bx_end = {1'b0, b.x} + {1'b0, b.w};
        by_end = {1'b0, b.y} + {1'b0, b.h};
        return (a.x >= b.x) && (a.y >= b.y) && (ax_end <= bx_end) && (ay_end <= by_end);
    endfunction

    function automatic logic fn_overlap(mrbp_pkg::rect_t a, mrbp_pkg::rect_t b);
        logic [EW-1:0] ax_end, ay_end, bx_end, by_end;
        ax_end = {1'b0, a.x} + {1'b0, a.w};
        ay_end = {1'b0, a.y} + {1'b0, a.h};
        bx_end = {1'b0, b.x} + {1'b0, b.w};
        by_end = {1'b0, b.y} + {1'b0, b.h};
        return ({1'b0, a.x} < bx_end) && ({1'b0, b.x} < ax_end) &&
               ({1'b0, a.y} < by_end) && ({1'b0, b.y} < ay_end);
    endfunction

    mrbp_pkg::rect_t free_mem [MAX_FREE_RECTS];
    mrbp_pkg::rect_t scr_mem  [S];
    mrbp_pkg::rect_t free_rd_reg, scr_rd_reg, hold_reg;

    mrbp_pkg::coord_t   bin_w_reg, bin_h_reg;
    logic               req_cmd_reg;
    mrbp_pkg::coord_t   req_w_reg, req_h_reg;
    mrbp_pkg::coord_t   used_x_reg, used_y_reg;
    logic               found_reg;
    logic [AW-1:0]      best_area_reg;
    logic [CNTW-1:0]    total_reg, wr_reg;
    logic [SCW-1:0]     addr_reg, n_reg, i_reg, alive_cnt_reg;
    logic               pend_reg;
    logic [SI-1:0]      pend_idx_reg;
    logic [1:0]         piece_reg;
    logic [S-1:0]       alive_reg;
    mrbp_pkg::status_t  res_status_reg;
    mrbp_pkg::coord_t   res_x_reg, res_y_reg;
    logic               m_tvalid_reg;
    mrbp_pkg::status_t  m_status_reg;
    mrbp_pkg::coord_t   m_x_reg, m_y_reg;
    logic [6:0]         m_count_reg;

    mrbp_pkg::rect_t    used_rect, cut_rect, clear_rect;
    logic               cut_cond, fits, scan_better, keep_push, cut_push;
    logic               hit_i, hit_j, free_issue, scr_issue;
    logic [AW-1:0]      area;
    logic [EW-1:0]      ux_end, uy_end, fx_end, fy_end;
    logic [SI-1:0]      scr_ra;
    logic               free_we, scr_we;
    logic [FI-1:0]      free_wa;
    mrbp_pkg::rect_t    free_wd, scr_wd;

    assign used_rect = '{x: used_x_reg, y: used_y_reg, w: req_w_reg, h: req_h_reg};

    assign clear_rect = '{x: '0, y: '0,
        w: (bin_w_reg > mrbp_pkg::COORD_MAX) ? mrbp_pkg::COORD_MAX : bin_w_reg,
        h: (bin_h_reg > mrbp_pkg::COORD_MAX) ? mrbp_pkg::COORD_MAX : bin_h_reg};

    assign ux_end = {1'b0, used_x_reg} + {1'b0, req_w_reg};
    assign uy_end = {1'b0, used_y_reg} + {1'b0, req_h_reg};
    assign fx_end = {1'b0, hold_reg.x} + {1'b0, hold_reg.w};
    assign fy_end = {1'b0, hold_reg.y} + {1'b0, hold_reg.h};

    always_comb begin
        cut_rect = hold_reg;
        cut_cond = 1'b0;
        case (piece_reg)
            2'd0: begin
                cut_cond   = used_x_reg > hold_reg.x;
                cut_rect.w = used_x_reg - hold_reg.x;
            end
            2'd1: begin
                cut_cond   = used_y_reg > hold_reg.y;
                cut_rect.h = used_y_reg - hold_reg.y;
            end
            2'd2: begin
                cut_cond   = ux_end < fx_end;
                cut_rect.x = ux_end[mrbp_pkg::CW-1:0];
                cut_rect.w = mrbp_pkg::CW'(fx_end - ux_end);
            end
            default: begin
                cut_cond   = uy_end < fy_end;
                cut_rect.y = uy_end[mrbp_pkg::CW-1:0];
                cut_rect.h = mrbp_pkg::CW'(fy_end - uy_end);
            end
        endcase
    end

    assign fits = (free_rd_reg.w >= req_w_reg) && (free_rd_reg.h >= req_h_reg);
    assign area = free_rd_reg.w * free_rd_reg.h;
    assign scan_better = pend_reg && fits && (!found_reg || area < best_area_reg);

    assign keep_push = (cmd.op == mrbp_pkg::OP_KEEP) && pend_reg &&
                       !fn_overlap(free_rd_reg, used_rect);
    assign cut_push  = (cmd.op == mrbp_pkg::OP_CUT_PIECE) && cut_cond &&
                       fn_overlap(hold_reg, used_rect);

    assign hit_i = pend_reg && alive_reg[pend_idx_reg] && fn_inside(hold_reg, scr_rd_reg);
    assign hit_j = pend_reg && alive_reg[pend_idx_reg] && !hit_i &&
                   fn_inside(scr_rd_reg, hold_reg);

    assign free_issue = addr_reg < SCW'(total_reg);
    assign scr_issue  = addr_reg < n_reg;

    assign scr_ra = (cmd.op == mrbp_pkg::OP_PRUNE_OUTER) ? i_reg[SI-1:0] : addr_reg[SI-1:0];

    always_comb begin
        free_we = 1'b0;
        free_wa = '0;
        free_wd = clear_rect;
        if (cmd.op == mrbp_pkg::OP_CLEAR) begin
            free_we = 1'b1;
        end else if (cmd.op == mrbp_pkg::OP_COMMIT && pend_reg && alive_reg[pend_idx_reg]) begin
            free_we = 1'b1;
            free_wa = wr_reg[FI-1:0];
            free_wd = scr_rd_reg;
        end
        scr_we = keep_push || cut_push;
        scr_wd = keep_push ? free_rd_reg : cut_rect;
    end

    always_ff @(posedge aclk) begin
        free_rd_reg <= free_mem[addr_reg[FI-1:0]];
        if (free_we) begin
            free_mem[free_wa] <= free_wd;
        end
    end

    always_ff @(posedge aclk) begin
        scr_rd_reg <= scr_mem[scr_ra];
        if (scr_we) begin
            scr_mem[n_reg[SI-1:0]] <= scr_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_w_reg    <= mrbp_pkg::BIN_RESET;
            bin_h_reg    <= mrbp_pkg::BIN_RESET;
            total_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    mrbp_pkg::CFG_BIN_WIDTH:  bin_w_reg <= cfg_data;
                    mrbp_pkg::CFG_BIN_HEIGHT: bin_h_reg <= cfg_data;
                endcase
            end
            if (scr_we) begin
                alive_reg[n_reg[SI-1:0]] <= 1'b1;
                n_reg <= n_reg + SCW'(1);
            end
            case (cmd.op)
                mrbp_pkg::OP_LOAD: begin
                    req_cmd_reg <= in_cmd;
                    req_w_reg   <= in_req_width;
                    req_h_reg   <= in_req_height;
                    found_reg   <= 1'b0;
                end
                mrbp_pkg::OP_RESTART: begin
                    addr_reg <= '0;
                    pend_reg <= 1'b0;
                    wr_reg   <= '0;
                end
                mrbp_pkg::OP_CLEAR: begin
                    total_reg <= CNTW'(1);
                end
                mrbp_pkg::OP_SCAN, mrbp_pkg::OP_KEEP: begin
                    pend_reg <= free_issue;
                    if (free_issue) begin
                        addr_reg <= addr_reg + SCW'(1);
                    end
                    if (cmd.op == mrbp_pkg::OP_SCAN && scan_better) begin
                        found_reg     <= 1'b1;
                        best_area_reg <= area;
                        used_x_reg    <= free_rd_reg.x;
                        used_y_reg    <= free_rd_reg.y;
                    end
                end
                mrbp_pkg::OP_KEEP_INIT: begin
                    addr_reg <= '0;
                    pend_reg <= 1'b0;
                    n_reg    <= '0;
                end
                mrbp_pkg::OP_CUT_FETCH: begin
                    if (free_issue) begin
                        addr_reg <= addr_reg + SCW'(1);
                    end
                end
                mrbp_pkg::OP_CUT_LATCH: begin
                    hold_reg  <= free_rd_reg;
                    piece_reg <= 2'd0;
                end
                mrbp_pkg::OP_CUT_PIECE: begin
                    piece_reg <= piece_reg + 2'd1;
                end
                mrbp_pkg::OP_PRUNE_INIT: begin
                    i_reg         <= '0;
                    alive_cnt_reg <= n_reg;
                end
                mrbp_pkg::OP_PRUNE_OUTER: begin
                    if (i_reg < n_reg && !alive_reg[i_reg[SI-1:0]]) begin
                        i_reg <= i_reg + SCW'(1);
                    end
                end
                mrbp_pkg::OP_PRUNE_LATCH: begin
                    hold_reg <= scr_rd_reg;
                    addr_reg <= i_reg + SCW'(1);
                    pend_reg <= 1'b0;
                end
                mrbp_pkg::OP_PRUNE_INNER: begin
                    pend_reg     <= scr_issue && !hit_i;
                    pend_idx_reg <= addr_reg[SI-1:0];
                    if (scr_issue) begin
                        addr_reg <= addr_reg + SCW'(1);
                    end
                    if (hit_i) begin
                        alive_reg[i_reg[SI-1:0]] <= 1'b0;
                        alive_cnt_reg <= alive_cnt_reg - SCW'(1);
                    end else if (hit_j) begin
                        alive_reg[pend_idx_reg] <= 1'b0;
                        alive_cnt_reg <= alive_cnt_reg - SCW'(1);
                    end
                    if (hit_i || (!scr_issue && !pend_reg)) begin
                        i_reg <= i_reg + SCW'(1);
                    end
                end
                mrbp_pkg::OP_COMMIT: begin
                    pend_reg     <= scr_issue;
                    pend_idx_reg <= addr_reg[SI-1:0];
                    if (scr_issue) begin
                        addr_reg <= addr_reg + SCW'(1);
                    end
                    if (free_we) begin
                        wr_reg <= wr_reg + CNTW'(1);
                    end
                    if (!scr_issue && !pend_reg) begin
                        total_reg <= alive_cnt_reg[CNTW-1:0];
                    end
                end
                default: begin
                end
            endcase
            if (cmd.set_result) begin
                res_status_reg <= cmd.result;
                res_x_reg <= (cmd.result == mrbp_pkg::STATUS_PLACED) ? used_x_reg : '0;
                res_y_reg <= (cmd.result == mrbp_pkg::STATUS_PLACED) ? used_y_reg : '0;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
                m_status_reg <= res_status_reg;
                m_x_reg      <= res_x_reg;
                m_y_reg      <= res_y_reg;
                m_count_reg  <= 7'(total_reg);
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.is_place   = req_cmd_reg;
    assign sts.free_done  = !free_issue && !pend_reg;
    assign sts.found      = found_reg;
    assign sts.cut_end    = !free_issue;
    assign sts.piece_last = piece_reg == 2'd3;
    assign sts.outer_end  = i_reg >= n_reg;
    assign sts.i_alive    = alive_reg[i_reg[SI-1:0]];
    assign sts.inner_end  = hit_i || (!scr_issue && !pend_reg);
    assign sts.overflow   = alive_cnt_reg > SCW'(MAX_FREE_RECTS);
    assign sts.scr_done   = !scr_issue && !pend_reg;
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid       = m_tvalid_reg;
    assign out_status     = m_status_reg;
    assign out_pos_x      = m_x_reg;
    assign out_pos_y      = m_y_reg;
    assign out_free_count = m_count_reg;

endmodule
`default_nettype wire
